// File: hdl/bed_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Button edge event detector package
// Shared constants, codes and the event record for the detector.
// ----------------------------------------------------------------------------
package bed_pkg;

  // Widest supported button word and the widths that follow from it.
  localparam int BUTTONS_MAX = 32;
  localparam int IDX_W       = 5;   // button index field
  localparam int CNT_W       = 6;   // buttons_in_use register
  localparam int TYPES_W     = 64;  // button_types register
  localparam int CFG_IDX_W   = 8;   // configuration register index
  localparam int OUT_DATA_W  = 8;   // button index padded to a byte

  // Button types, two bits per button.
  localparam logic [1:0] TYPE_NONE       = 2'd0;
  localparam logic [1:0] TYPE_TOGGLE     = 2'd1;
  localparam logic [1:0] TYPE_SHORT_LONG = 2'd2;
  localparam logic [1:0] TYPE_CONTINUOUS = 2'd3;

  // Input operations.
  localparam logic OP_DETECT   = 1'b0;
  localparam logic OP_SNAPSHOT = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_BUTTON_TYPES   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BUTTONS_IN_USE = 8'd1;

  // One event as it leaves the scanner.
  typedef struct packed {
    logic [IDX_W-1:0] button_index;
    logic             turned_on;
    logic             last_event;
  } bed_event_t;

endpackage

// File: hdl/bed_scan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Button edge event detector scanner
// Walks sample, stored states and types through shift registers one button per cycle,
// unless a held event cannot leave, and pushes events out with one event of lookahead.
// ----------------------------------------------------------------------------
module bed_scan #(
  parameter int BUTTON_COUNT = bed_pkg::BUTTONS_MAX
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start_i,
  input  logic                       start_op_i,
  input  logic [31:0]                start_word_i,
  input  logic [bed_pkg::TYPES_W-1:0] start_types_i,
  input  logic [bed_pkg::CNT_W-1:0]  start_count_i,
  output logic                       idle_o,
  output logic                       ev_push_o,
  output bed_pkg::bed_event_t        ev_o,
  input  logic                       ev_ready_i
);
  import bed_pkg::*;

  localparam int POS_W = (BUTTON_COUNT > 1) ? $clog2(BUTTON_COUNT) : 1;
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(BUTTON_COUNT - 1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_FLUSH = 2'd2;

  logic [1:0]                state_r, state_nxt;
  logic [POS_W-1:0]          pos_r, pos_nxt;
  logic                      op_r, op_nxt;
  logic [CNT_W-1:0]          count_r, count_nxt;
  logic [BUTTON_COUNT-1:0]   word_sr_r, word_sr_nxt;
  logic [2*BUTTON_COUNT-1:0] types_sr_r, types_sr_nxt;
  logic [BUTTON_COUNT-1:0]   prev_r, prev_nxt;
  logic                      pend_valid_r, pend_valid_nxt;
  logic [IDX_W-1:0]          pend_idx_r, pend_idx_nxt;
  logic                      pend_on_r, pend_on_nxt;

  logic                      now_bit, was_bit, in_range, hit, on_bit, stall;
  logic [1:0]                btype;
  logic [BUTTON_COUNT:0]     prev_shift;

  always_comb begin
    state_nxt      = state_r;
    pos_nxt        = pos_r;
    op_nxt         = op_r;
    count_nxt      = count_r;
    word_sr_nxt    = word_sr_r;
    types_sr_nxt   = types_sr_r;
    prev_nxt       = prev_r;
    pend_valid_nxt = pend_valid_r;
    pend_idx_nxt   = pend_idx_r;
    pend_on_nxt    = pend_on_r;
    ev_push_o      = 1'b0;
    ev_o           = '0;

    now_bit  = word_sr_r[0];
    was_bit  = prev_r[0];
    btype    = types_sr_r[1:0];
    in_range = CNT_W'(pos_r) < count_r;

    // Edge classification for the button at the head of the shift registers.
    hit    = 1'b0;
    on_bit = 1'b1;
    case (btype)
      TYPE_TOGGLE: begin
        if (now_bit && !was_bit) begin
          hit = 1'b1;
        end else if (!now_bit && was_bit) begin
          hit    = 1'b1;
          on_bit = 1'b0;
        end
      end
      TYPE_SHORT_LONG: begin
        hit = now_bit && !was_bit;
      end
      TYPE_CONTINUOUS: begin
        hit = now_bit;
      end
      default: begin
        hit = 1'b0;
      end
    endcase
    hit = hit && in_range && (op_r == OP_DETECT);

    // A new event can only be taken when the held one can leave.
    stall      = hit && pend_valid_r && !ev_ready_i;
    prev_shift = {(in_range ? now_bit : was_bit), prev_r};

    case (state_r)
      ST_IDLE: begin
        if (start_i) begin
          word_sr_nxt    = start_word_i[BUTTON_COUNT-1:0];
          types_sr_nxt   = start_types_i[2*BUTTON_COUNT-1:0];
          op_nxt         = start_op_i;
          count_nxt      = start_count_i;
          pos_nxt        = '0;
          pend_valid_nxt = 1'b0;
          state_nxt      = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (!stall) begin
          if (hit && pend_valid_r) begin
            ev_push_o = 1'b1;
            ev_o      = '{button_index: pend_idx_r, turned_on: pend_on_r,
                          last_event: 1'b0};
          end
          if (hit) begin
            pend_valid_nxt = 1'b1;
            pend_idx_nxt   = IDX_W'(pos_r);
            pend_on_nxt    = on_bit;
          end
          // The stored word rotates once around, taking the sample in range.
          prev_nxt     = prev_shift[BUTTON_COUNT:1];
          word_sr_nxt  = word_sr_r >> 1;
          types_sr_nxt = types_sr_r >> 2;
          if (pos_r == POS_LAST) begin
            state_nxt = ST_FLUSH;
          end else begin
            pos_nxt = pos_r + 1'b1;
          end
        end
      end
      ST_FLUSH: begin
        if (!pend_valid_r) begin
          state_nxt = ST_IDLE;
        end else if (ev_ready_i) begin
          ev_push_o      = 1'b1;
          ev_o           = '{button_index: pend_idx_r, turned_on: pend_on_r,
                             last_event: 1'b1};
          pend_valid_nxt = 1'b0;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign idle_o = (state_r == ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      pos_r        <= '0;
      prev_r       <= '0;
      pend_valid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      pos_r        <= pos_nxt;
      prev_r       <= prev_nxt;
      pend_valid_r <= pend_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    count_r    <= count_nxt;
    word_sr_r  <= word_sr_nxt;
    types_sr_r <= types_sr_nxt;
    pend_idx_r <= pend_idx_nxt;
    pend_on_r  <= pend_on_nxt;
  end

endmodule

// File: hdl/button_edge_event_detector.sv
`timescale 1ns / 1ps
// The scanner examines one button per cycle unless the result side stalls, and
// takes a new sample only once the scan of the previous one has ended. Reset
// clears the stored button states, sets button_types to all none and
// buttons_in_use to 32, and empties the output register.
// ----------------------------------------------------------------------------
// Button edge event detector
// Compares each sampled button word with the stored one and emits on and off events
// per button type, in ascending button order, the last one marked; a snapshot only stores.
// ----------------------------------------------------------------------------
module button_edge_event_detector #(
  parameter int BUTTON_COUNT = bed_pkg::BUTTONS_MAX
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // Sample input channel.
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [31:0]                    in_tdata,   // [31:0] button_word
  input  logic                           in_tuser,   // [0] operation
  // Event output channel.
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [bed_pkg::OUT_DATA_W-1:0] out_tdata,  // [4:0] button_index, rest 0
  output logic                           out_tuser,  // [0] turned_on
  output logic                           out_tlast,  // last_event
  // Configuration write channel.
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [bed_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bed_pkg::TYPES_W-1:0]    cfg_data
);
  import bed_pkg::*;

  localparam logic [CNT_W-1:0] COUNT_LIMIT = CNT_W'(BUTTON_COUNT);

  logic [TYPES_W-1:0] types_r;
  logic [CNT_W-1:0]   in_use_r;
  logic [CNT_W-1:0]   count_eff;

  logic               scan_idle;
  logic               ev_push;
  bed_event_t         ev;
  logic               slot_free;

  logic               out_valid_r, out_valid_nxt;
  bed_event_t         out_ev_r;

  // Configuration registers accept a write in every cycle. Writes to an
  // index outside the register list are dropped.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      types_r  <= '0;
      in_use_r <= CNT_W'(BUTTONS_MAX);
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_BUTTON_TYPES:   types_r  <= cfg_data;
        REG_BUTTONS_IN_USE: in_use_r <= cfg_data[CNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // A count above the number of buttons examines all of them.
  assign count_eff = (in_use_r > COUNT_LIMIT) ? COUNT_LIMIT : in_use_r;

  // A sample is taken only while the scanner is free; the output register
  // may still hold the final event of the previous sample at that time.
  assign in_tready = scan_idle;

  // The scanner pushes an event only when the output register is empty or
  // its content is being transferred in the same cycle.
  assign slot_free = !out_valid_r || out_tready;

  bed_scan #(
    .BUTTON_COUNT(BUTTON_COUNT)
  ) u_scan (
    .clk          (clk),
    .rst_n        (rst_n),
    .start_i      (in_tvalid && in_tready),
    .start_op_i   (in_tuser),
    .start_word_i (in_tdata),
    .start_types_i(types_r),
    .start_count_i(count_eff),
    .idle_o       (scan_idle),
    .ev_push_o    (ev_push),
    .ev_o         (ev),
    .ev_ready_i   (slot_free)
  );

  // Output register between the scanner and the result channel.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (ev_push) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ev_push) begin
      out_ev_r <= ev;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_DATA_W'(out_ev_r.button_index);
  assign out_tuser  = out_ev_r.turned_on;
  assign out_tlast  = out_ev_r.last_event;

endmodule

// File: tb/bed_event_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Button event checker
// Watches the sample, event and register channels of the detector, keeps its
// own copy of the stored button states and registers, and compares every
// event transfer with the oldest predicted event.
// ----------------------------------------------------------------------------
module bed_event_checker #(
  parameter int BUTTON_COUNT = bed_pkg::BUTTONS_MAX
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  input  logic                           in_tready,
  input  logic [31:0]                    in_tdata,   // [31:0] button_word
  input  logic                           in_tuser,   // [0] operation
  input  logic                           out_tvalid,
  input  logic                           out_tready,
  input  logic [bed_pkg::OUT_DATA_W-1:0] out_tdata,  // [4:0] button_index, rest 0
  input  logic                           out_tuser,  // [0] turned_on
  input  logic                           out_tlast,  // last_event
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [bed_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bed_pkg::TYPES_W-1:0]    cfg_data,
  output int                             fail_count,
  output int                             pending,
  output int                             events_checked
);
  import bed_pkg::*;

  logic [TYPES_W-1:0]     types_q;
  logic [CNT_W-1:0]       count_q;
  logic [BUTTONS_MAX-1:0] stored_buttons;
  bed_event_t             expected_events[$];
  int                     errors;
  int                     matched;

  initial begin
    errors  = 0;
    matched = 0;
  end

  // Works out the events one sample causes and queues them in button order.
  task automatic predict_sample(input logic op, input logic [31:0] word);
    int                     n;
    int                     top;
    logic [31:0]            mask;
    logic [31:0]            hits;
    logic [31:0]            ons;
    logic [1:0]             kind;
    logic                   now_b;
    logic                   was_b;
    bed_event_t             ev;
    n    = (int'(count_q) > BUTTON_COUNT) ? BUTTON_COUNT : int'(count_q);
    mask = (n >= 32) ? '1 : ((32'd1 << n) - 32'd1);
    hits = '0;
    ons  = '0;
    top  = -1;
    if (op == OP_DETECT) begin
      for (int i = 0; i < n; i++) begin
        kind  = types_q[2*i +: 2];
        now_b = word[i];
        was_b = stored_buttons[i];
        case (kind)
          TYPE_TOGGLE, TYPE_SHORT_LONG: begin
            if (now_b && !was_b) begin
              hits[i] = 1'b1;
              ons[i]  = 1'b1;
            end else if (!now_b && was_b && kind == TYPE_TOGGLE) begin
              hits[i] = 1'b1;
            end
          end
          TYPE_CONTINUOUS: begin
            if (now_b) begin
              hits[i] = 1'b1;
              ons[i]  = 1'b1;
            end
          end
          default: ;
        endcase
        if (hits[i]) top = i;
      end
      for (int i = 0; i < n; i++) begin
        if (hits[i]) begin
          ev.button_index = i[IDX_W-1:0];
          ev.turned_on    = ons[i];
          ev.last_event   = (i == top);
          expected_events.push_back(ev);
        end
      end
    end
    stored_buttons = (stored_buttons & ~mask) | (word & mask);
  endtask

  task automatic check_event();
    bed_event_t want;
    if (expected_events.size() == 0) begin
      $error("Unexpected event: button_index %0d, turned_on %0b, last_event %0b",
             out_tdata[IDX_W-1:0], out_tuser, out_tlast);
      errors++;
    end else begin
      want = expected_events.pop_front();
      if (out_tdata[IDX_W-1:0] !== want.button_index) begin
        $error("button_index: expected %0d, actual %0d",
               want.button_index, out_tdata[IDX_W-1:0]);
        errors++;
      end
      if (out_tuser !== want.turned_on) begin
        $error("turned_on: expected %0b, actual %0b", want.turned_on, out_tuser);
        errors++;
      end
      if (out_tlast !== want.last_event) begin
        $error("last_event: expected %0b, actual %0b", want.last_event, out_tlast);
        errors++;
      end
      if (out_tdata[OUT_DATA_W-1:IDX_W] !== '0) begin
        $error("tdata padding: expected 0, actual %0h", out_tdata[OUT_DATA_W-1:IDX_W]);
        errors++;
      end
      matched++;
    end
  endtask

  // Outputs leave through nonblocking assignments so the stimulus side always
  // sees the values from before the edge.
  always @(posedge clk) begin
    if (!rst_n) begin
      types_q        = '0;
      count_q        = CNT_W'(BUTTONS_MAX);
      stored_buttons = '0;
      expected_events.delete();
    end else begin
      if (out_tvalid && out_tready) check_event();
      if (in_tvalid && in_tready) predict_sample(in_tuser, in_tdata);
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_BUTTON_TYPES) types_q = cfg_data;
        else if (cfg_index == REG_BUTTONS_IN_USE) count_q = cfg_data[CNT_W-1:0];
      end
    end
    fail_count     <= errors;
    pending        <= expected_events.size();
    events_checked <= matched;
  end

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Button edge event detector testbench
// Drives button samples and register writes into the detector, with random
// gaps on the sample side and random stalls on the event side. A checker
// beside the detector predicts every event and counts mismatches; this top
// only makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module testbench;
  import bed_pkg::*;

  localparam int BUTTON_COUNT = BUTTONS_MAX;
  // Settle time that covers one whole scan of a sample with room to spare.
  localparam int SETTLE_CYCLES = BUTTON_COUNT + 10;
  // Length of the one long hold-off on the event side.
  localparam int HOLD_CYCLES = 400;
  localparam int PHASE_ITEMS = 15;
  localparam int RANDOM_PHASES = 6;
  // Register indexes that do not exist; writes to them must change nothing.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED    = REG_BUTTONS_IN_USE + 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INDEX_TOP = '1;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  // Every input of the detector starts at a known value.
  logic                    in_tvalid = 1'b0;
  logic                    in_tready;
  logic [31:0]             in_tdata = '0;
  logic                    in_tuser = OP_DETECT;
  logic                    out_tvalid;
  logic                    out_tready = 1'b0;
  logic [OUT_DATA_W-1:0]   out_tdata;
  logic                    out_tuser;
  logic                    out_tlast;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [CFG_IDX_W-1:0]    cfg_index = '0;
  logic [TYPES_W-1:0]      cfg_data = '0;

  int fail_count;
  int pending;
  int events_checked;

  // Stimulus controls shared by the sending and receiving processes.
  logic        no_gaps = 1'b0;
  logic        sender_eager = 1'b0;
  logic        hold_request = 1'b0;
  logic [31:0] last_word = '0;
  int          samples_sent = 0;
  int          snapshots_sent = 0;
  int          regs_written = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  button_edge_event_detector #(
    .BUTTON_COUNT(BUTTON_COUNT)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  bed_event_checker #(
    .BUTTON_COUNT(BUTTON_COUNT)
  ) checker_i (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tuser      (in_tuser),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tuser     (out_tuser),
    .out_tlast     (out_tlast),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .fail_count    (fail_count),
    .pending       (pending),
    .events_checked(events_checked)
  );

  // Most gaps are short or absent, a few are long enough to span a whole scan.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps) return 0;
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Offers one sample and returns at the edge where its transfer happens. The
  // valid stays high so a back-to-back sample never drops it in between.
  task automatic send_sample(input logic op, input logic [31:0] word);
    int gap;
    gap = sender_eager ? 0 : pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= word;
    in_tuser  <= op;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    last_word = word;
    samples_sent++;
    if (op == OP_SNAPSHOT) snapshots_sent++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                           input logic [TYPES_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
    regs_written++;
  endtask

  // Registers may only change while the detector is idle. First every predicted
  // event must have left; then a sample that caused no event may still be in
  // its scan, so a further settle time passes.
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic configure(input logic [TYPES_W-1:0] types, input logic [TYPES_W-1:0] count);
    wait_idle();
    write_reg(REG_BUTTON_TYPES, types);
    write_reg(REG_BUTTONS_IN_USE, count);
  endtask

  // A new random setting: either one type for every button or a random mix,
  // and a button count that often sits at an extreme.
  task automatic random_setting();
    logic [TYPES_W-1:0] types;
    logic [TYPES_W-1:0] count;
    logic [1:0]         kind;
    kind = 2'($urandom_range(0, 3));
    if ($urandom_range(0, 2) == 0) types = {32{kind}};
    else types = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0:       count = 64'd0;
      1:       count = 64'd1;
      2:       count = 64'd31;
      3, 4:    count = 64'd32;
      5:       count = 64'd33;
      6:       count = 64'd63;
      default: count = 64'($urandom_range(0, 63));
    endcase
    // The upper bits of the count write are ignored by the register.
    count[TYPES_W-1:CNT_W] = (TYPES_W-CNT_W)'({$urandom, $urandom} >> CNT_W);
    configure(types, count);
  endtask

  // Random samples. Words flip a few bits of the previous word often, so the
  // edge logic sees realistic button activity alongside fully random words.
  task automatic random_phase(input int items);
    logic        op;
    logic [31:0] word;
    for (int k = 0; k < items; k++) begin
      op = ($urandom_range(0, 9) == 0) ? OP_SNAPSHOT : OP_DETECT;
      case ($urandom_range(0, 9))
        0, 1, 2, 3: word = $urandom;
        4, 5, 6:    word = last_word ^ ($urandom & $urandom & $urandom);
        7:          word = '1;
        8:          word = '0;
        default:    word = last_word ^ (32'd1 << $urandom_range(0, 31));
      endcase
      send_sample(op, word);
    end
  endtask

  // Event side: random stalls, and once a long hold-off on request while the
  // sample side keeps offering, so the detector backs up and stalls its input.
  initial begin
    int stall;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_request) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_request = 1'b0;
      end else begin
        stall = pick_gap();
        if (stall > 0) begin
          out_tready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
        out_tready <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. After reset every button has no type, so even a word of
    // all pressed buttons produces no event while still being stored.
    send_sample(OP_DETECT, 32'hFFFF_FFFF);

    // All toggles: full falling and rising sweeps, alternating patterns, and a
    // snapshot that must move the stored state without any event.
    configure({32{TYPE_TOGGLE}}, 64'd32);
    send_sample(OP_DETECT, 32'h0000_0000);
    send_sample(OP_DETECT, 32'hFFFF_FFFF);
    send_sample(OP_DETECT, 32'hAAAA_AAAA);
    send_sample(OP_DETECT, 32'h5555_5555);
    send_sample(OP_SNAPSHOT, 32'hFFFF_FFFF);
    send_sample(OP_DETECT, 32'hFFFF_FFFF);
    send_sample(OP_DETECT, 32'h0000_0001);

    // Short/long press on a single button: only the rising edge reports.
    configure({32{TYPE_SHORT_LONG}}, 64'd1);
    send_sample(OP_DETECT, 32'h0000_0000);
    send_sample(OP_DETECT, 32'hFFFF_FFFF);
    send_sample(OP_DETECT, 32'h0000_0000);

    // A count of zero examines and stores nothing, snapshots included.
    configure({32{TYPE_CONTINUOUS}}, 64'd0);
    send_sample(OP_DETECT, 32'hFFFF_FFFF);
    send_sample(OP_SNAPSHOT, 32'h1234_5678);

    // Counts above the button limit saturate to all buttons.
    configure({32{TYPE_CONTINUOUS}}, 64'd63);
    send_sample(OP_DETECT, 32'hFFFF_FFFF);
    send_sample(OP_DETECT, 32'h8000_0000);
    configure({32{TYPE_TOGGLE}}, 64'd33);
    send_sample(OP_DETECT, 32'h0000_0001);

    // A mixed setting one below the limit, then writes to indexes that do not
    // exist, which must leave both registers alone.
    configure({$urandom, $urandom}, 64'd31);
    send_sample(OP_DETECT, $urandom);
    send_sample(OP_DETECT, $urandom);
    send_sample(OP_DETECT, 32'hFFFF_FFFF);
    wait_idle();
    write_reg(REG_UNUSED, {$urandom, $urandom});
    write_reg(REG_INDEX_TOP, {$urandom, $urandom});
    send_sample(OP_DETECT, $urandom);
    send_sample(OP_SNAPSHOT, $urandom);
    send_sample(OP_DETECT, $urandom);

    // Random part, one new setting per phase.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      if (p == 2) begin
        // Every held button reports, so the event side backs up quickly while
        // it holds off and the samples keep coming without gaps.
        configure({32{TYPE_CONTINUOUS}}, 64'd32);
        hold_request = 1'b1;
        sender_eager = 1'b1;
        random_phase(PHASE_ITEMS);
        sender_eager = 1'b0;
      end else begin
        random_setting();
        no_gaps = (p == 4);
        random_phase(PHASE_ITEMS);
        no_gaps = 1'b0;
      end
    end

    // Drain: all predicted events must arrive, then nothing more may follow.
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Run covered %0d samples (%0d snapshots), %0d events checked, %0d register writes.",
             samples_sent, snapshots_sent, events_checked, regs_written);
    $display("Settings included counts 0, 1, 31, 32, 33 and 63, every button type, and a long stall.");
    if (pending != 0) $error("%0d predicted events never arrived", pending);
    if (fail_count == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog well beyond the slowest correct run.
  initial begin
    #2000000;
    $error("Timeout with %0d events still predicted", pending);
    $display("*** FAILED ***");
    $finish;
  end

endmodule
